// File: rtl/tpo2d_pkg.sv
// shared types, vertex tables and decision-tree functions for the triangle overlap test
package tpo2d_pkg;

  localparam int NUM_PTS = 6;
  localparam int NUM_TRI = 20;

  typedef logic [2:0] pt_idx_t;
  typedef logic [4:0] tri_idx_t;

  localparam pt_idx_t PT_A0 = 3'd0;
  localparam pt_idx_t PT_A1 = 3'd1;
  localparam pt_idx_t PT_A2 = 3'd2;
  localparam pt_idx_t PT_B0 = 3'd3;
  localparam pt_idx_t PT_B1 = 3'd4;
  localparam pt_idx_t PT_B2 = 3'd5;

  // every sorted vertex triple i < j < k
  localparam pt_idx_t TRI_I [NUM_TRI] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3};
  localparam pt_idx_t TRI_J [NUM_TRI] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4};
  localparam pt_idx_t TRI_K [NUM_TRI] = '{
    3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5,
    3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5};

  localparam tri_idx_t TRI_A = 5'd0;
  localparam tri_idx_t TRI_B = 5'd19;

  typedef struct packed {
    logic neg;
    logic zero;
  } osign_t;

  typedef osign_t [NUM_TRI-1:0] osign_vec_t;

  function automatic osign_t orient_sign(osign_vec_t v, pt_idx_t x, pt_idx_t y, pt_idx_t z);
    pt_idx_t  a;
    pt_idx_t  b;
    pt_idx_t  c;
    pt_idx_t  t;
    logic     flip;
    tri_idx_t idx;
    osign_t   r;
    a    = x;
    b    = y;
    c    = z;
    flip = 1'b0;
    idx  = '0;
    if (a > b) begin
      t = a; a = b; b = t; flip = ~flip;
    end
    if (b > c) begin
      t = b; b = c; c = t; flip = ~flip;
    end
    if (a > b) begin
      t = a; a = b; b = t; flip = ~flip;
    end
    for (int n = 0; n < NUM_TRI; n++) begin
      if (TRI_I[n] == a && TRI_J[n] == b && TRI_K[n] == c) begin
        idx = tri_idx_t'(n);
      end
    end
    r = v[idx];
    // odd permutation flips the sign
    if (flip) begin
      r.neg = ~r.neg & ~r.zero;
    end
    return r;
  endfunction

  function automatic logic o_ge(osign_vec_t v, pt_idx_t x, pt_idx_t y, pt_idx_t z);
    osign_t s;
    s = orient_sign(v, x, y, z);
    return ~s.neg;
  endfunction

  function automatic logic o_le(osign_vec_t v, pt_idx_t x, pt_idx_t y, pt_idx_t z);
    osign_t s;
    s = orient_sign(v, x, y, z);
    return s.neg | s.zero;
  endfunction

  function automatic logic o_gt(osign_vec_t v, pt_idx_t x, pt_idx_t y, pt_idx_t z);
    osign_t s;
    s = orient_sign(v, x, y, z);
    return ~s.neg & ~s.zero;
  endfunction

  function automatic logic vertex_case(osign_vec_t v, pt_idx_t p1, pt_idx_t q1, pt_idx_t r1,
                                       pt_idx_t p2, pt_idx_t q2, pt_idx_t r2);
    logic res;
    if (o_ge(v, r2, p2, q1)) begin
      if (o_le(v, r2, q2, q1)) begin
        if (o_gt(v, p1, p2, q1)) begin
          res = o_le(v, p1, q2, q1);
        end else begin
          res = o_ge(v, p1, p2, r1) & o_ge(v, q1, r1, p2);
        end
      end else begin
        res = o_le(v, p1, q2, q1) & o_le(v, r2, q2, r1) & o_ge(v, q1, r1, q2);
      end
    end else if (o_ge(v, r2, p2, r1)) begin
      if (o_ge(v, q1, r1, r2)) begin
        res = o_ge(v, p1, p2, r1);
      end else begin
        res = o_ge(v, q1, r1, q2) & o_ge(v, r2, r1, q2);
      end
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  function automatic logic edge_case(osign_vec_t v, pt_idx_t p1, pt_idx_t q1, pt_idx_t r1,
                                     pt_idx_t p2, pt_idx_t r2);
    logic res;
    if (o_ge(v, r2, p2, q1)) begin
      if (o_ge(v, p1, p2, q1)) begin
        res = o_ge(v, p1, q1, r2);
      end else begin
        res = o_ge(v, q1, r1, p2) & o_ge(v, r1, p1, p2);
      end
    end else if (o_ge(v, r2, p2, r1) && o_ge(v, p1, p2, r1)) begin
      res = o_ge(v, p1, r1, r2) | o_ge(v, q1, r1, r2);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  function automatic logic ccw_overlap(osign_vec_t v, pt_idx_t p1, pt_idx_t q1, pt_idx_t r1,
                                       pt_idx_t p2, pt_idx_t q2, pt_idx_t r2);
    logic res;
    if (o_ge(v, p2, q2, p1)) begin
      if (o_ge(v, q2, r2, p1)) begin
        if (o_ge(v, r2, p2, p1)) begin
          res = 1'b1;
        end else begin
          res = edge_case(v, p1, q1, r1, p2, r2);
        end
      end else if (o_ge(v, r2, p2, p1)) begin
        res = edge_case(v, p1, q1, r1, r2, q2);
      end else begin
        res = vertex_case(v, p1, q1, r1, p2, q2, r2);
      end
    end else if (o_ge(v, q2, r2, p1)) begin
      if (o_ge(v, r2, p2, p1)) begin
        res = edge_case(v, p1, q1, r1, q2, p2);
      end else begin
        res = vertex_case(v, p1, q1, r1, q2, r2, p2);
      end
    end else begin
      res = vertex_case(v, p1, q1, r1, r2, p2, q2);
    end
    return res;
  endfunction

endpackage

// File: rtl/triangle_pair_overlap_2d.sv
// triangle pair overlap test: four-stage pipeline over all vertex-triple orientations
// Takes one pair of 2D triangles per cycle while in_stall is low and returns one
// overlap flag per beat from the stage 4 register. Stage 1 forms the coordinate
// differences of all 20 vertex triples, stage 2 the 40 products of
// (COORD_WIDTH+1)-bit factors, stage 3 compares the product pairs into the sign of
// each orientation, and stage 4 orders both triangles counter-clockwise and walks the
// decision tree over those signs. Touching triangles report overlap. Each stage moves
// on when it is empty or the next one moves, so bubbles close up and in_stall rises
// only when all four stages hold a beat and out_stall is high.
module triangle_pair_overlap_2d #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax0,
  input  logic signed [COORD_WIDTH-1:0] ay0,
  input  logic signed [COORD_WIDTH-1:0] ax1,
  input  logic signed [COORD_WIDTH-1:0] ay1,
  input  logic signed [COORD_WIDTH-1:0] ax2,
  input  logic signed [COORD_WIDTH-1:0] ay2,
  input  logic signed [COORD_WIDTH-1:0] bx0,
  input  logic signed [COORD_WIDTH-1:0] by0,
  input  logic signed [COORD_WIDTH-1:0] bx1,
  input  logic signed [COORD_WIDTH-1:0] by1,
  input  logic signed [COORD_WIDTH-1:0] bx2,
  input  logic signed [COORD_WIDTH-1:0] by2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          overlap
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] px [tpo2d_pkg::NUM_PTS];
  logic signed [DW-1:0] py [tpo2d_pkg::NUM_PTS];

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [DW-1:0] d0 [tpo2d_pkg::NUM_TRI];
  logic signed [DW-1:0] d1 [tpo2d_pkg::NUM_TRI];
  logic signed [DW-1:0] d2 [tpo2d_pkg::NUM_TRI];
  logic signed [DW-1:0] d3 [tpo2d_pkg::NUM_TRI];
  logic signed [PW-1:0] m0 [tpo2d_pkg::NUM_TRI];
  logic signed [PW-1:0] m1 [tpo2d_pkg::NUM_TRI];
  tpo2d_pkg::osign_vec_t osign;
  tpo2d_pkg::osign_vec_t osign_next;

  logic             overlap_next;
  tpo2d_pkg::pt_idx_t q1, r1, q2, r2;

  assign en4      = ~v4 | ~out_stall;
  assign en3      = ~v3 | en4;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign in_stall = ~en1;
  assign out_valid = v4;

  always_comb begin
    px[0] = DW'(ax0); py[0] = DW'(ay0);
    px[1] = DW'(ax1); py[1] = DW'(ay1);
    px[2] = DW'(ax2); py[2] = DW'(ay2);
    px[3] = DW'(bx0); py[3] = DW'(by0);
    px[4] = DW'(bx1); py[4] = DW'(by1);
    px[5] = DW'(bx2); py[5] = DW'(by2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: differences against the third vertex of each triple
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int t = 0; t < tpo2d_pkg::NUM_TRI; t++) begin
        d0[t] <= px[tpo2d_pkg::TRI_I[t]] - px[tpo2d_pkg::TRI_K[t]];
        d1[t] <= py[tpo2d_pkg::TRI_J[t]] - py[tpo2d_pkg::TRI_K[t]];
        d2[t] <= py[tpo2d_pkg::TRI_I[t]] - py[tpo2d_pkg::TRI_K[t]];
        d3[t] <= px[tpo2d_pkg::TRI_J[t]] - px[tpo2d_pkg::TRI_K[t]];
      end
    end
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int t = 0; t < tpo2d_pkg::NUM_TRI; t++) begin
        m0[t] <= PW'(d0[t]) * PW'(d1[t]);
        m1[t] <= PW'(d2[t]) * PW'(d3[t]);
      end
    end
  end

  // stage 3: orientation sign per triple
  always_comb begin
    for (int t = 0; t < tpo2d_pkg::NUM_TRI; t++) begin
      osign_next[t].neg  = m0[t] < m1[t];
      osign_next[t].zero = m0[t] == m1[t];
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      osign <= osign_next;
    end
  end

  // stage 4: counter-clockwise order and decision tree
  always_comb begin
    q1 = osign[tpo2d_pkg::TRI_A].neg ? tpo2d_pkg::PT_A2 : tpo2d_pkg::PT_A1;
    r1 = osign[tpo2d_pkg::TRI_A].neg ? tpo2d_pkg::PT_A1 : tpo2d_pkg::PT_A2;
    q2 = osign[tpo2d_pkg::TRI_B].neg ? tpo2d_pkg::PT_B2 : tpo2d_pkg::PT_B1;
    r2 = osign[tpo2d_pkg::TRI_B].neg ? tpo2d_pkg::PT_B1 : tpo2d_pkg::PT_B2;
    overlap_next = tpo2d_pkg::ccw_overlap(osign, tpo2d_pkg::PT_A0, q1, r1,
                                          tpo2d_pkg::PT_B0, q2, r2);
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      overlap <= overlap_next;
    end
  end

endmodule

// File: rtl/tpo2d_chk.sv
// port-level checker for the triangle overlap pipeline, bound to the top level
module tpo2d_chk (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic overlap
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(overlap))
    else $error("stalled result beat changed");

  // input backs up only when the output is full and stalled
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind triangle_pair_overlap_2d tpo2d_chk u_tpo2d_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .overlap   (overlap)
);

// File: tb/tb_top.sv
// testbench for the 2d triangle pair overlap test: random and corner-case pairs, checked in order
`timescale 1ns / 1ps

module tb_top;

  localparam int CW          = 16;
  localparam int CMIN        = -(2 ** (CW - 1));
  localparam int CMAX        = 2 ** (CW - 1) - 1;
  localparam int PER_PHASE   = 544;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_SHAPES  = 21;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax0, ay0, ax1, ay1, ax2, ay2;
    coord_t bx0, by0, bx1, by1, bx2, by2;
  } tri_pair_t;

  typedef struct {
    longint x;
    longint y;
  } vtx_t;

  typedef enum {SPAN_FULL, SPAN_CLUSTER, SPAN_TINY, SPAN_EDGE} span_t;

  class overlap_board;
    bit pending_overlap[$];
    int mismatch_count;
    int beat_count;

    function longint turn(vtx_t a, vtx_t b, vtx_t c);
      return (a.x - c.x) * (b.y - c.y) - (a.y - c.y) * (b.x - c.x);
    endfunction

    function vtx_t at(coord_t x, coord_t y);
      vtx_t v;
      v.x = longint'(x);
      v.y = longint'(y);
      return v;
    endfunction

    function bit corner_test(vtx_t p1, vtx_t q1, vtx_t r1, vtx_t p2, vtx_t q2, vtx_t r2);
      if (turn(r2, p2, q1) >= 0) begin
        if (turn(r2, q2, q1) <= 0) begin
          if (turn(p1, p2, q1) > 0) return turn(p1, q2, q1) <= 0;
          return turn(p1, p2, r1) >= 0 && turn(q1, r1, p2) >= 0;
        end
        return turn(p1, q2, q1) <= 0 && turn(r2, q2, r1) <= 0 && turn(q1, r1, q2) >= 0;
      end
      if (turn(r2, p2, r1) >= 0) begin
        if (turn(q1, r1, r2) >= 0) return turn(p1, p2, r1) >= 0;
        return turn(q1, r1, q2) >= 0 && turn(r2, r1, q2) >= 0;
      end
      return 1'b0;
    endfunction

    function bit side_test(vtx_t p1, vtx_t q1, vtx_t r1, vtx_t p2, vtx_t r2);
      if (turn(r2, p2, q1) >= 0) begin
        if (turn(p1, p2, q1) >= 0) return turn(p1, q1, r2) >= 0;
        return turn(q1, r1, p2) >= 0 && turn(r1, p1, p2) >= 0;
      end
      if (turn(r2, p2, r1) >= 0 && turn(p1, p2, r1) >= 0) begin
        return turn(p1, r1, r2) >= 0 || turn(q1, r1, r2) >= 0;
      end
      return 1'b0;
    endfunction

    function bit ccw_hit(vtx_t p1, vtx_t q1, vtx_t r1, vtx_t p2, vtx_t q2, vtx_t r2);
      if (turn(p2, q2, p1) >= 0) begin
        if (turn(q2, r2, p1) >= 0) begin
          if (turn(r2, p2, p1) >= 0) return 1'b1;
          return side_test(p1, q1, r1, p2, r2);
        end
        if (turn(r2, p2, p1) >= 0) return side_test(p1, q1, r1, r2, q2);
        return corner_test(p1, q1, r1, p2, q2, r2);
      end
      if (turn(q2, r2, p1) >= 0) begin
        if (turn(r2, p2, p1) >= 0) return side_test(p1, q1, r1, q2, p2);
        return corner_test(p1, q1, r1, q2, r2, p2);
      end
      return corner_test(p1, q1, r1, r2, p2, q2);
    endfunction

    function bit overlap_of(tri_pair_t p);
      vtx_t a0, a1, a2, b0, b1, b2, t;
      a0 = at(p.ax0, p.ay0);
      a1 = at(p.ax1, p.ay1);
      a2 = at(p.ax2, p.ay2);
      b0 = at(p.bx0, p.by0);
      b1 = at(p.bx1, p.by1);
      b2 = at(p.bx2, p.by2);
      // clockwise triangles get vertices 1 and 2 swapped, degenerate ones stay
      if (turn(a0, a1, a2) < 0) begin
        t = a1; a1 = a2; a2 = t;
      end
      if (turn(b0, b1, b2) < 0) begin
        t = b1; b1 = b2; b2 = t;
      end
      return ccw_hit(a0, a1, a2, b0, b1, b2);
    endfunction

    function void note_pair(tri_pair_t p);
      pending_overlap.push_back(overlap_of(p));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_hit(logic got);
      bit want;
      beat_count++;
      if (pending_overlap.size() == 0) begin
        report($sformatf("result beat %0d overlap=%b with nothing pending", beat_count, got));
        return;
      end
      want = pending_overlap.pop_front();
      if (got !== want) begin
        report($sformatf("result beat %0d overlap got %b want %b", beat_count, got, want));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      overlap;
  tri_pair_t drv = '0;

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  overlap_board board;

  localparam int SHAPES [NUM_SHAPES][12] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
    '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
    '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX},
    '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX},
    '{CMIN, CMIN, -32760, CMIN, CMIN, -32760, CMAX, CMAX, 32760, CMAX, CMAX, 32760},
    '{0, 0, 10, 0, 0, 10, 10, 0, 20, 0, 10, 10},
    '{0, 0, 10, 0, 0, 10, 10, 0, 0, 10, 10, 10},
    '{0, 0, 10, 0, 0, 10, 11, 0, 1, 10, 11, 10},
    '{-100, -100, 100, -100, 0, 100, -1, 0, 1, 0, 0, 1},
    '{-1, 0, 1, 0, 0, 1, -100, -100, 100, -100, 0, 100},
    '{0, 0, 0, 10, 10, 0, 2, 2, 20, 2, 2, 20},
    '{0, 0, 5, 5, 10, 10, 0, 10, 10, 0, 10, 10},
    '{0, 0, 1, 1, 2, 2, 10, 0, 20, 0, 10, 10},
    '{0, 0, 10, 0, 0, 10, 1, 1, 1, 1, 1, 1},
    '{0, 0, 12, 0, 6, 10, 0, 7, 12, 7, 6, -3},
    '{CMIN, CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMAX},
    '{21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, 21845, -21846, -21846, 21845},
    '{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, 5, 5, 5, 5, -5, -5},
    '{0, 0, 10, 0, 0, 10, 20, 20, 30, 20, 20, 30},
    '{5, -5, -5, 5, -5, -5, 0, 0, 0, 0, 0, 0}
  };

  triangle_pair_overlap_2d #(
    .COORD_WIDTH(CW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ax0      (drv.ax0),
    .ay0      (drv.ay0),
    .ax1      (drv.ax1),
    .ay1      (drv.ay1),
    .ax2      (drv.ax2),
    .ay2      (drv.ay2),
    .bx0      (drv.bx0),
    .by0      (drv.by0),
    .bx1      (drv.bx1),
    .by1      (drv.by1),
    .bx2      (drv.bx2),
    .by2      (drv.by2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .overlap  (overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t pick_coord(span_t s, int hub);
    int v;
    case (s)
      SPAN_FULL:    v = int'($urandom);
      SPAN_CLUSTER: v = hub + int'($urandom_range(1400)) - 700;
      SPAN_TINY:    v = hub + int'($urandom_range(8)) - 4;
      default: begin
        case ($urandom_range(5))
          0:       v = CMIN;
          1:       v = CMAX;
          2:       v = CMIN + 1;
          3:       v = CMAX - 1;
          4:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return coord_t'(v);
  endfunction

  function automatic tri_pair_t random_pair();
    int    r;
    int    hub;
    span_t s;
    r   = int'($urandom_range(9));
    hub = int'($urandom_range(64000)) - 32000;
    s   = r < 3 ? SPAN_FULL : r < 7 ? SPAN_CLUSTER : r < 9 ? SPAN_TINY : SPAN_EDGE;
    return {pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub),
            pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub),
            pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub), pick_coord(s, hub)};
  endfunction

  task automatic send_pair(input tri_pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    drv      = p;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(p);
    @(negedge clk);
  endtask

  // result side: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_hit(overlap);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tri_pair_t shape;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle = 32;
    recv_idle = 78;
    for (int i = 0; i < NUM_SHAPES; i++) begin
      for (int j = 0; j < 12; j++) shape[(11 - j) * CW +: CW] = coord_t'(SHAPES[i][j]);
      send_pair(shape);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 32 : ph == 1 ? 78 : 0;
      recv_idle = ph == 0 ? 78 : ph == 1 ? 32 : 0;
      for (int k = 0; k < PER_PHASE; k++) begin
        if (ph == 2 && k == 60) hold_req = 1'b1;
        send_pair(random_pair());
      end
    end
    in_valid = 1'b0;

    while (board.pending_overlap.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
